// ===== src/mclfo_pkg.sv =====
package mclfo_pkg;

    // sizing
    localparam int NUM_LFOS        = 4;
    localparam int SINE_INDEX_BITS = 8;
    localparam int PHASE_BITS      = 24;

    localparam int CFG_CHANNELS = 4;
    localparam int COUNT_BITS   = 16;
    localparam int LEVEL_BITS   = 13;
    localparam int CHAN_BITS    = 3;
    localparam int TIMER_BITS   = 25;
    localparam int ADDR_BITS    = 6;
    localparam int DATA_BITS    = 64;
    localparam int REG_IDX_BITS = 3;
    localparam int PROD_BITS    = COUNT_BITS + PHASE_BITS;
    localparam int SINE_QBITS   = SINE_INDEX_BITS - 2;
    localparam int SINE_QUARTER = 1 << SINE_QBITS;
    localparam int SIDX_BITS    = SINE_QBITS + 1;
    localparam int OUTQ_DEPTH   = 4;
    localparam int OUTQ_PTR     = 2;

    // register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_LFO_A    = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_LFO_B    = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_LFO_C    = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_LFO_D    = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_BLOCK_EN = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_RAND_EN  = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_INTERVAL = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_SEED     = 3'd7;

    // command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // wave codes
    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_SAW      = 3'd1;
    localparam logic [2:0] WAVE_SQUARE   = 3'd2;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [2:0] WAVE_HELD     = 3'd4;

    localparam logic [CHAN_BITS-1:0]  RANDOM_CHANNEL = 3'd4;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX      = 25'h1FFFFFF;
    localparam logic [LEVEL_BITS-1:0] LEVEL_HALF     = 13'd2048;
    localparam logic [LEVEL_BITS-1:0] LEVEL_FULL     = 13'd4096;

    // reset values
    localparam logic [63:0] SETTINGS_RESET = 64'd2252349569504736;
    localparam logic [23:0] INTERVAL_RESET = 24'd4800;
    localparam logic [31:0] SEED_RESET     = 32'd1;

    typedef struct packed {
        logic [CFG_CHANNELS-1:0][63:0] settings;
        logic                          block_enable;
        logic                          random_enable;
        logic [23:0]                   random_interval;
        logic [31:0]                   random_seed;
    } t_cfg;

    typedef struct packed {
        logic                  is_start;
        logic [COUNT_BITS-1:0] count;
    } t_item;

    typedef struct packed {
        logic [CHAN_BITS-1:0]  channel;
        logic [LEVEL_BITS-1:0] level;
        logic                  last;
    } t_result;

    // xorshift32 with shifts 13, 17, 5
    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] x;
        x = s ^ (s << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    // quarter wave sine magnitude in 1.11, odd polynomial in Q30
    function automatic logic [11:0] quarter_mag(input int unsigned idx);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] m;
        u  = 64'(idx) << (30 - SINE_QBITS);
        u2 = (u * u) >> 30;
        p  = 64'd172272;
        p  = 64'd5026994 - ((u2 * p) >> 30);
        p  = 64'd85569306 - ((u2 * p) >> 30);
        p  = 64'd693598669 - ((u2 * p) >> 30);
        p  = 64'd1686629713 - ((u2 * p) >> 30);
        q  = (u * p) >> 30;
        m  = ((q << 11) + (64'd1 << 29)) >> 30;
        if (m > 64'd2048) begin
            m = 64'd2048;
        end
        return 12'(m);
    endfunction

endpackage

// ===== src/multi_channel_lfo_unit.sv =====
// start word: handled by the sequencer in its idle state, no results
// tick word: the serial channel sequencer, sharing one datapath, takes each enabled
// lfo channel through next, multiply, phase, level and out, then the random channel
// through rand if it fires; out and rand wait while the result queue is full, and
// each disabled channel ahead of a result adds a pass through the next state
// one word is worked at a time; two more wait in the input queue
// synchronous active-low reset sets config, pointers and control state to defaults
module multi_channel_lfo_unit
    import mclfo_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_command,
    input  logic [COUNT_BITS-1:0] i_sample_count,
    output logic                  empty,
    input  logic                  pop,
    output logic [CHAN_BITS-1:0]  o_channel,
    output logic [LEVEL_BITS-1:0] o_level,
    output logic                  o_last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready
);

    t_cfg    w_cfg;
    logic    w_item_valid;
    t_item   w_item;
    logic    w_item_pop;
    logic    w_res_push;
    t_result w_res;
    logic    w_res_full;
    t_result w_out;

    // configuration registers
    mclfo_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // input queue and classification
    mclfo_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_command      (i_command),
        .i_sample_count (i_sample_count),
        .i_block_enable (w_cfg.block_enable),
        .o_full         (full),
        .o_item_valid   (w_item_valid),
        .o_item         (w_item),
        .i_item_pop     (w_item_pop)
    );

    // channel sequencer and datapath
    mclfo_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .o_res_push   (w_res_push),
        .o_res        (w_res),
        .i_res_full   (w_res_full)
    );

    // result queue
    mclfo_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_push),
        .i_wdata (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .i_rd    (pop),
        .o_rdata (w_out)
    );

    assign o_channel = w_out.channel;
    assign o_level   = w_out.level;
    assign o_last    = w_out.last;

`ifndef SYNTHESIS
    // sequencer never writes a full result queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_res_push && w_res_full))
        else $error("result written while queue full");

    // the random channel always closes its tick
    a_random_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_channel == RANDOM_CHANNEL)) |-> o_last)
        else $error("random result not marked last");

    // levels stay in range
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_level <= LEVEL_FULL) && (o_channel <= RANDOM_CHANNEL)))
        else $error("result word out of range");
`endif

endmodule

// ===== src/mclfo_regs.sv =====
module mclfo_regs
    import mclfo_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output t_cfg                 o_cfg
);

    t_cfg                    r_cfg;
    logic [REG_IDX_BITS-1:0] w_idx;
    logic                    w_wr;

    assign w_idx  = paddr[ADDR_BITS-1 -: REG_IDX_BITS];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_CHANNELS; i++) begin
                r_cfg.settings[i] <= SETTINGS_RESET;
            end
            r_cfg.block_enable    <= 1'b1;
            r_cfg.random_enable   <= 1'b0;
            r_cfg.random_interval <= INTERVAL_RESET;
            r_cfg.random_seed     <= SEED_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_LFO_A:    r_cfg.settings[0] <= pwdata;
                REG_LFO_B:    r_cfg.settings[1] <= pwdata;
                REG_LFO_C:    r_cfg.settings[2] <= pwdata;
                REG_LFO_D:    r_cfg.settings[3] <= pwdata;
                REG_BLOCK_EN: r_cfg.block_enable <= pwdata[0];
                REG_RAND_EN:  r_cfg.random_enable <= pwdata[0];
                REG_INTERVAL: r_cfg.random_interval <= pwdata[23:0];
                REG_SEED:     r_cfg.random_seed <= pwdata[31:0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_LFO_A:    prdata = r_cfg.settings[0];
            REG_LFO_B:    prdata = r_cfg.settings[1];
            REG_LFO_C:    prdata = r_cfg.settings[2];
            REG_LFO_D:    prdata = r_cfg.settings[3];
            REG_BLOCK_EN: prdata = {63'd0, r_cfg.block_enable};
            REG_RAND_EN:  prdata = {63'd0, r_cfg.random_enable};
            REG_INTERVAL: prdata = {40'd0, r_cfg.random_interval};
            REG_SEED:     prdata = {32'd0, r_cfg.random_seed};
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== src/mclfo_front.sv =====
module mclfo_front
    import mclfo_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_command,
    input  logic [COUNT_BITS-1:0] i_sample_count,
    input  logic                  i_block_enable,
    output logic                  o_full,
    output logic                  o_item_valid,
    output t_item                 o_item,
    input  logic                  i_item_pop
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_accept;
    logic       w_keep;
    logic       w_pop;

    assign o_full       = (r_cnt == 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rp];
    assign w_accept     = i_push && !o_full;
    // a tick while the block is off does nothing, so it is dropped here
    assign w_keep       = w_accept && ((i_command == CMD_START) || i_block_enable);
    assign w_pop        = i_item_pop && o_item_valid;

    // word storage
    always_ff @(posedge i_clk) begin
        if (w_keep) begin
            r_mem[r_wp].is_start <= (i_command == CMD_START);
            r_mem[r_wp].count    <= i_sample_count;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_keep) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_keep} - {1'b0, w_pop};
        end
    end

endmodule

// ===== src/mclfo_outq.sv =====
module mclfo_outq
    import mclfo_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_wdata,
    output logic    o_full,
    output logic    o_empty,
    input  logic    i_rd,
    output t_result o_rdata
);

    t_result               r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR-1:0]   r_wp;
    logic [OUTQ_PTR-1:0]   r_rp;
    logic [OUTQ_PTR:0]     r_cnt;
    logic                  w_wr;
    logic                  w_rd;

    assign o_full  = (r_cnt == (OUTQ_PTR + 1)'(OUTQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    // word storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (OUTQ_PTR + 1)'(w_wr) - (OUTQ_PTR + 1)'(w_rd);
        end
    end

endmodule

// ===== src/mclfo_back.sv =====
module mclfo_back
    import mclfo_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_item_pop,
    output logic    o_res_push,
    output t_result o_res,
    input  logic    i_res_full
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NEXT  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_PHASE = 3'd3;
    localparam logic [2:0] S_LEVEL = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_RAND  = 3'd6;

    logic [2:0]                   r_state;
    logic [CHAN_BITS-1:0]         r_ch;
    logic [4:0]                   r_mask;
    logic [COUNT_BITS-1:0]        r_count;
    logic [PROD_BITS-1:0]         r_prod;
    logic [24:0]                  r_scaled;
    logic [PHASE_BITS-1:0]        r_phase [CFG_CHANNELS];
    logic [11:0]                  r_held  [CFG_CHANNELS];
    logic [TIMER_BITS-1:0]        r_timer;
    logic [31:0]                  r_rng;

    logic [1:0]                   w_ci;
    logic [63:0]                  w_set;
    logic [2:0]                   w_wave;
    logic [PHASE_BITS-1:0]        w_inc;
    logic [11:0]                  w_amp;
    logic [11:0]                  w_off;
    logic [PROD_BITS-1:0]         w_sum;
    logic                         w_wrap;
    logic [31:0]                  w_rng_next;
    logic [PHASE_BITS-1:0]        w_ph;
    logic [SINE_INDEX_BITS-1:0]   w_sin_i;
    logic [SIDX_BITS-1:0]         w_sidx;
    logic [11:0]                  w_smag;
    logic [LEVEL_BITS-1:0]        w_sine;
    logic [PHASE_BITS:0]          w_tri_rem;
    logic [LEVEL_BITS-1:0]        w_tri;
    logic [LEVEL_BITS-1:0]        w_wlvl;
    logic signed [26:0]           w_v;
    logic [26:0]                  w_vr;
    logic [LEVEL_BITS-1:0]        w_shape;
    logic [CFG_CHANNELS-1:0]      w_en;
    logic [TIMER_BITS:0]          w_tsum;
    logic [TIMER_BITS-1:0]        w_tsat;
    logic                         w_rfire;
    logic                         w_last;
    logic [11:0]                  w_sine_tab [SINE_QUARTER + 1];

    // quarter wave table, constant per entry
    for (genvar g = 0; g <= SINE_QUARTER; g++) begin : g_sine
        localparam logic [11:0] MAG = quarter_mag(g);
        assign w_sine_tab[g] = MAG;
    end

    // current channel fields
    assign w_ci   = r_ch[1:0];
    assign w_set  = i_cfg.settings[w_ci];
    assign w_wave = w_set[2:0];
    assign w_inc  = PHASE_BITS'(w_set[27:4] >> (24 - PHASE_BITS));
    assign w_amp  = w_set[39:28];
    assign w_off  = w_set[51:40];

    // phase advance and wrap
    assign w_sum      = PROD_BITS'(r_phase[w_ci]) + r_prod;
    assign w_wrap     = |w_sum[PROD_BITS-1:PHASE_BITS];
    assign w_rng_next = xorshift32(r_rng);

    // sine lookup with quadrant folding
    assign w_ph    = r_phase[w_ci];
    assign w_sin_i = w_ph[PHASE_BITS-1 -: SINE_INDEX_BITS];
    assign w_sidx  = w_sin_i[SINE_QBITS] ?
                     SIDX_BITS'(SINE_QUARTER) - {1'b0, w_sin_i[SINE_QBITS-1:0]} :
                     {1'b0, w_sin_i[SINE_QBITS-1:0]};
    assign w_smag  = w_sine_tab[w_sidx];
    assign w_sine  = w_sin_i[SINE_INDEX_BITS-1] ? LEVEL_HALF - {1'b0, w_smag} :
                                                  LEVEL_HALF + {1'b0, w_smag};

    // triangle: rising half or falling half
    assign w_tri_rem = {1'b1, {PHASE_BITS{1'b0}}} - {1'b0, w_ph};
    assign w_tri     = w_ph[PHASE_BITS-1] ? w_tri_rem[PHASE_BITS-1 -: LEVEL_BITS] :
                                            w_ph[PHASE_BITS-1 -: LEVEL_BITS];

    // wave select
    always_comb begin
        case (w_wave)
            WAVE_SINE:     w_wlvl = w_sine;
            WAVE_SAW:      w_wlvl = {1'b0, w_ph[PHASE_BITS-1 -: 12]};
            WAVE_SQUARE:   w_wlvl = w_ph[PHASE_BITS-1] ? '0 : LEVEL_FULL;
            WAVE_TRIANGLE: w_wlvl = w_tri;
            WAVE_HELD:     w_wlvl = {1'b0, r_held[w_ci]};
            default:       w_wlvl = '0;
        endcase
    end

    // offset, recentre, round and clamp
    assign w_v  = $signed({2'b00, r_scaled}) + $signed({3'b000, w_off, 12'd0})
                - $signed({4'b0000, w_amp, 11'd0});
    assign w_vr = w_v + 27'sd2048;
    always_comb begin
        if (w_v < 0) begin
            w_shape = '0;
        end else if (w_vr[26:12] > 15'(LEVEL_FULL)) begin
            w_shape = LEVEL_FULL;
        end else begin
            w_shape = w_vr[24:12];
        end
    end

    // channels taking part in a tick
    always_comb begin
        for (int i = 0; i < CFG_CHANNELS; i++) begin
            w_en[i] = (i < NUM_LFOS) && i_cfg.settings[i][3];
        end
    end

    // random timer, saturating
    assign w_tsum  = (TIMER_BITS + 1)'(r_timer) + (TIMER_BITS + 1)'(i_item.count);
    assign w_tsat  = w_tsum[TIMER_BITS] ? TIMER_MAX : w_tsum[TIMER_BITS-1:0];
    assign w_rfire = i_cfg.random_enable &&
                     (w_tsat >= TIMER_BITS'(i_cfg.random_interval));

    // last word: no later channel fires
    always_comb begin
        w_last = 1'b1;
        for (int i = 0; i < 5; i++) begin
            if ((3'(i) > r_ch) && r_mask[i]) begin
                w_last = 1'b0;
            end
        end
    end

    // result word
    assign o_item_pop = (r_state == S_IDLE) && i_item_valid;
    assign o_res_push = ((r_state == S_OUT) || (r_state == S_RAND)) && !i_res_full;
    always_comb begin
        if (r_state == S_RAND) begin
            o_res.channel = RANDOM_CHANNEL;
            o_res.level   = {1'b0, w_rng_next[31:20]};
        end else begin
            o_res.channel = r_ch;
            o_res.level   = w_shape;
        end
        o_res.last = w_last;
    end

    // channel sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
            r_mask  <= '0;
            r_timer <= '0;
            r_rng   <= 32'd1;
            for (int i = 0; i < CFG_CHANNELS; i++) begin
                r_phase[i] <= '0;
                r_held[i]  <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        if (i_item.is_start) begin
                            for (int i = 0; i < CFG_CHANNELS; i++) begin
                                r_phase[i] <= {i_cfg.settings[i][63:52],
                                               {(PHASE_BITS - 12){1'b0}}};
                            end
                            r_timer <= '0;
                            r_rng   <= (i_cfg.random_seed != 32'd0) ?
                                       i_cfg.random_seed : 32'd1;
                        end else begin
                            r_count <= i_item.count;
                            r_mask  <= {w_rfire, w_en};
                            if (i_cfg.random_enable) begin
                                r_timer <= w_rfire ? '0 : w_tsat;
                            end
                            r_ch    <= '0;
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_NEXT: begin
                    if (r_mask[r_ch]) begin
                        r_state <= (r_ch == RANDOM_CHANNEL) ? S_RAND : S_MUL;
                    end else if (r_ch == RANDOM_CHANNEL) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_ch <= r_ch + 1'b1;
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_BITS'(r_count) * PROD_BITS'(w_inc);
                    r_state <= S_PHASE;
                end
                S_PHASE: begin
                    r_phase[w_ci] <= w_sum[PHASE_BITS-1:0];
                    if ((w_wave == WAVE_HELD) && w_wrap) begin
                        r_held[w_ci] <= w_rng_next[31:20];
                        r_rng        <= w_rng_next;
                    end
                    r_state <= S_LEVEL;
                end
                S_LEVEL: begin
                    r_scaled <= 25'(w_wlvl) * 25'(w_amp);
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (!i_res_full) begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_NEXT;
                    end
                end
                S_RAND: begin
                    if (!i_res_full) begin
                        r_rng   <= w_rng_next;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
